// ----- sv/assert_macros.svh -----
// Assertion macros shared by the sanitizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define UTS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never be seen at a clock edge.
`define UTS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- sv/uts_pkg.sv -----
// Shared types and constants of the UTF-8 terminal text sanitizer.
package uts_pkg;

    localparam logic [31:0] MAX_LEN          = 32'd65535;
    localparam int          UTS_QUEUE_DEPTH  = 4;
    localparam logic [15:0] BYTE_LIMIT_RESET = 16'd4095;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_INVALID
    } uts_cls_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        uts_cls_t   cls;
    } uts_item_t;

    typedef struct packed {
        logic [15:0] total_count;
        logic        msg_end;
        logic        has_byte;
        logic [7:0]  out_byte;
    } uts_result_t;

endpackage

// ----- sv/uts_front.sv -----
// Front end: accepts input beats and classifies each byte for the decoder.
module uts_front
    import uts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    input  logic       q_full,
    output logic       q_push,
    output uts_item_t  q_item
);

    logic rst_seen_reg;

    function automatic uts_cls_t classify(input logic [7:0] b);
        uts_cls_t c;
        priority if (b <= 8'h7F) c = CLS_ASCII;
        else if (b <= 8'hBF)     c = CLS_CONT;
        else if (b < 8'hC2)      c = CLS_INVALID;
        else if (b <= 8'hDF)     c = CLS_LEAD2;
        else if (b <= 8'hEF)     c = CLS_LEAD3;
        else if (b <= 8'hF4)     c = CLS_LEAD4;
        else                     c = CLS_INVALID;
        return c;
    endfunction

    // Hold off the upstream side after reset release until rst_seen_reg is set.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rst_seen_reg <= 1'b0;
        end
        else
        begin
            rst_seen_reg <= 1'b1;
        end
    end

    assign s_tready    = rst_seen_reg && !q_full;
    assign q_push      = s_tvalid && s_tready;
    assign q_item.data = s_tdata;
    assign q_item.last = s_tlast;
    assign q_item.cls  = classify(s_tdata);

endmodule

// ----- sv/uts_queue.sv -----
// Short item queue between the front end and the decoder.
module uts_queue
    import uts_pkg::*;
#(
    parameter int DEPTH = UTS_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  uts_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output uts_item_t head_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    uts_item_t       slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- sv/uts_back.sv -----
// Back end: strict UTF-8 decode, unsafe codepoint filter, byte limit and output register.
module uts_back
    import uts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  uts_item_t   q_item,
    output logic        q_pop,
    input  logic [15:0] lim,
    output logic        out_valid,
    input  logic        out_ready,
    output uts_result_t out_res
);

    localparam logic [7:0] QMARK = 8'h3F;

    typedef enum logic [1:0] {ST_IDLE, ST_DECODE, ST_COPY, ST_FINISH} state_t;
    typedef enum logic [1:0] {DEC_WAIT, DEC_BAD, DEC_OK} dec_t;

    state_t      state_reg, state_next;
    logic [7:0]  byte_reg [4];
    logic [7:0]  byte_next [4];
    uts_cls_t    cls_reg [4];
    uts_cls_t    cls_next [4];
    logic [2:0]  len_reg, len_next;
    logic        last_reg, last_next;
    logic [2:0]  left_reg, left_next;
    logic [15:0] emitted_reg, emitted_next;
    logic        stopped_reg, stopped_next;
    logic        hold_valid_reg, hold_valid_next;
    uts_result_t hold_reg, hold_next;
    logic        out_valid_reg, out_valid_next;
    uts_result_t out_reg, out_next;

    logic [2:0]  need;
    logic        cont_ok;
    logic        over_bad;
    dec_t        dec;
    logic [20:0] cp;
    logic        safe;
    logic        fits;
    logic        at_limit;
    logic        out_free;

    function automatic logic cp_safe(input logic [20:0] c);
        logic ok;
        ok = 1'b1;
        if (c == 21'h0D || c == 21'h0A || c == 21'h09)
        begin
            ok = 1'b1;
        end
        else if (c < 21'h20 || (c >= 21'h7F && c <= 21'h9F))
        begin
            ok = 1'b0;
        end
        else if (c == 21'h2028 || c == 21'h2029)
        begin
            ok = 1'b0;
        end
        else if ((c >= 21'h202A && c <= 21'h202E) || (c >= 21'h2066 && c <= 21'h2069))
        begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign at_limit  = (emitted_reg >= lim);

    // Decode of the sequence that starts at the head of the byte window.
    always_comb
    begin
        unique case (cls_reg[0])
            CLS_ASCII: need = 3'd1;
            CLS_LEAD2: need = 3'd2;
            CLS_LEAD3: need = 3'd3;
            CLS_LEAD4: need = 3'd4;
            default:   need = 3'd0;
        endcase
        cont_ok = (need < 3'd2 || cls_reg[1] == CLS_CONT)
               && (need < 3'd3 || cls_reg[2] == CLS_CONT)
               && (need < 3'd4 || cls_reg[3] == CLS_CONT);
        over_bad = (byte_reg[0] == 8'hE0 && byte_reg[1] <  8'hA0)
                || (byte_reg[0] == 8'hED && byte_reg[1] >= 8'hA0)
                || (byte_reg[0] == 8'hF0 && byte_reg[1] <  8'h90)
                || (byte_reg[0] == 8'hF4 && byte_reg[1] >  8'h8F);
        priority if (need == 3'd0)    dec = DEC_BAD;
        else if (len_reg < need)      dec = last_reg ? DEC_BAD : DEC_WAIT;
        else if (!cont_ok || over_bad) dec = DEC_BAD;
        else                          dec = DEC_OK;
        unique case (need)
            3'd2:    cp = {10'd0, byte_reg[0][4:0], byte_reg[1][5:0]};
            3'd3:    cp = {5'd0, byte_reg[0][3:0], byte_reg[1][5:0], byte_reg[2][5:0]};
            3'd4:    cp = {byte_reg[0][2:0], byte_reg[1][5:0], byte_reg[2][5:0],
                           byte_reg[3][5:0]};
            default: cp = {13'd0, byte_reg[0]};
        endcase
        safe = cp_safe(cp);
        fits = ({1'b0, emitted_reg} + 17'(need)) <= {1'b0, lim};
    end

    always_comb
    begin
        logic        gen;
        uts_result_t res;
        logic [2:0]  shift;
        logic [2:0]  src;

        gen   = 1'b0;
        res   = '0;
        shift = 3'd0;
        src   = 3'd0;
        q_pop = 1'b0;

        state_next      = state_reg;
        byte_next       = byte_reg;
        cls_next        = cls_reg;
        len_next        = len_reg;
        last_next       = last_reg;
        left_next       = left_reg;
        emitted_next    = emitted_reg;
        stopped_next    = stopped_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    last_next = q_item.last;
                    if (stopped_reg || at_limit)
                    begin
                        len_next   = 3'd0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        byte_next[len_reg[1:0]] = q_item.data;
                        cls_next[len_reg[1:0]]  = q_item.cls;
                        len_next   = len_reg + 3'd1;
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_DECODE:
            begin
                if (out_free)
                begin
                    if (len_reg == 3'd0 || at_limit)
                    begin
                        len_next   = 3'd0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        unique case (dec)
                            DEC_WAIT:
                            begin
                                state_next = ST_FINISH;
                            end
                            DEC_BAD:
                            begin
                                gen   = 1'b1;
                                res.out_byte = QMARK;
                                shift = 3'd1;
                            end
                            DEC_OK:
                            begin
                                if (!safe)
                                begin
                                    gen   = 1'b1;
                                    res.out_byte = QMARK;
                                    shift = need;
                                end
                                else if (!fits)
                                begin
                                    // The whole sequence would pass the limit.
                                    stopped_next = 1'b1;
                                    len_next     = 3'd0;
                                    state_next   = ST_FINISH;
                                end
                                else
                                begin
                                    left_next  = need;
                                    state_next = ST_COPY;
                                end
                            end
                            default:
                            begin
                                state_next = ST_FINISH;
                            end
                        endcase
                    end
                end
            end
            ST_COPY:
            begin
                if (out_free)
                begin
                    gen          = 1'b1;
                    res.out_byte = byte_reg[0];
                    shift        = 3'd1;
                    left_next    = left_reg - 3'd1;
                    if (left_reg == 3'd1)
                    begin
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    if (last_reg)
                    begin
                        out_valid_next = 1'b1;
                        if (hold_valid_reg)
                        begin
                            out_next         = hold_reg;
                            out_next.msg_end = 1'b1;
                        end
                        else
                        begin
                            out_next             = '0;
                            out_next.msg_end     = 1'b1;
                            out_next.total_count = emitted_reg;
                        end
                        emitted_next = '0;
                        stopped_next = 1'b0;
                        len_next     = 3'd0;
                    end
                    else if (hold_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = hold_reg;
                    end
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (shift != 3'd0)
        begin
            for (int i = 0; i < 4; i++)
            begin
                src = 3'(i) + shift;
                if (!src[2])
                begin
                    byte_next[i] = byte_reg[src[1:0]];
                    cls_next[i]  = cls_reg[src[1:0]];
                end
            end
            len_next = len_reg - shift;
        end

        // The newest result waits in the hold stage until the next one comes or the step
        // ends, so that the end mark can still be set on it.
        if (gen)
        begin
            emitted_next    = emitted_reg + 16'd1;
            res.has_byte    = 1'b1;
            res.total_count = emitted_reg + 16'd1;
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = hold_reg;
            end
            hold_valid_next = 1'b1;
            hold_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            last_reg       <= 1'b0;
            left_reg       <= '0;
            emitted_reg    <= '0;
            stopped_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            last_reg       <= last_next;
            left_reg       <= left_next;
            emitted_reg    <= emitted_next;
            stopped_reg    <= stopped_next;
            hold_valid_reg <= hold_valid_next;
            hold_reg       <= hold_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        cls_reg  <= cls_next;
    end

endmodule

// ----- sv/utf8_terminal_text_sanitizer.sv -----
// Top level: the back end handles one byte at a time, and the input queue lets the front end
// take beats while the back end works or stalls.
// Reset clears the queue, the pending bytes, the counters and sets byte_limit to 4095.
// No clearing pass follows reset; beats are taken once rst_seen_reg is set after release.
`include "assert_macros.svh"

module utf8_terminal_text_sanitizer
    import uts_pkg::*;
#(
    parameter int QUEUE_DEPTH = UTS_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] total_count
    output logic        m_tlast,   // msg_end
    output logic        m_tuser,   // [0] has_byte
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // byte_limit
);

    logic        q_full;
    logic        q_push;
    uts_item_t   q_in_item;
    logic        q_pop;
    logic        q_not_empty;
    uts_item_t   q_head_item;
    logic [15:0] byte_limit_reg;
    logic [15:0] lim;
    uts_result_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_limit_reg <= BYTE_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            byte_limit_reg <= cfg_data;
        end
    end

    // The effective limit is the register clipped to the largest message length.
    assign lim = ({16'd0, byte_limit_reg} > MAX_LEN) ? MAX_LEN[15:0] : byte_limit_reg;

    uts_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in_item)
    );

    uts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (q_head_item)
    );

    uts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_item    (q_head_item),
        .q_pop     (q_pop),
        .lim       (lim),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {res.total_count, res.out_byte};
    assign m_tlast = res.msg_end;
    assign m_tuser = res.has_byte;

    `UTS_ASSERT_IMPLIES(a_bare_marker_ends, m_tvalid && !m_tuser, m_tlast, "marker not last")
    `UTS_ASSERT_IMPLIES(a_byte_counted, m_tvalid && m_tuser, |m_tdata[23:8], "zero count")
    `UTS_ASSERT_NEVER(a_bare_marker_zero, m_tvalid && !m_tuser && |m_tdata[7:0], "marker data")

endmodule

// ----- dv/tb_utf8_terminal_text_sanitizer.sv -----
// Self-checking testbench for the streaming UTF-8 terminal text sanitizer.
module tb_utf8_terminal_text_sanitizer;
    import uts_pkg::*;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int END_CYCLES      = 60;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASE_ITEMS     = 40;
    localparam logic [7:0] QMARK   = 8'h3F;

    typedef enum logic [1:0] {
        SEQ_SHORT,
        SEQ_BAD,
        SEQ_GOOD
    } seq_status_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = 16'h0000;

    // Sanitizer state as the testbench sees it.
    logic [15:0] limit_q = BYTE_LIMIT_RESET;
    logic [7:0]  held_bytes [0:2];
    int          held_n     = 0;
    int          sent_n     = 0;
    bit          overflowed = 1'b0;
    logic [7:0]  seq_win [0:3];

    uts_result_t expected_out[$];
    uts_result_t step_tail;
    bit          step_has_tail;

    logic [7:0]  msg_bytes[$];
    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    bit          hold_request = 1'b0;
    int          stall_cycles = 0;
    int          mismatches   = 0;

    utf8_terminal_text_sanitizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Strict decode of the sequence that starts at seq_win[pos].
    function automatic seq_status_t decode_seq_at(input int pos, input int avail,
                                                  input bit at_end, output int seq_len,
                                                  output logic [20:0] cp);
        logic [7:0] lead;
        int         need;
        lead    = seq_win[pos];
        seq_len = 1;
        cp      = {13'd0, lead};
        if (lead <= 8'h7F)
            return SEQ_GOOD;
        if (lead >= 8'hC2 && lead <= 8'hDF)
        begin
            need = 2;
            cp   = {16'd0, lead[4:0]};
        end
        else if (lead >= 8'hE0 && lead <= 8'hEF)
        begin
            need = 3;
            cp   = {17'd0, lead[3:0]};
        end
        else if (lead >= 8'hF0 && lead <= 8'hF4)
        begin
            need = 4;
            cp   = {18'd0, lead[2:0]};
        end
        else
            return SEQ_BAD;
        if (avail < need)
            return at_end ? SEQ_BAD : SEQ_SHORT;
        for (int i = 1; i < need; i++)
        begin
            if (seq_win[pos + i][7:6] != 2'b10)
                return SEQ_BAD;
            cp = (cp << 6) | {15'd0, seq_win[pos + i][5:0]};
        end
        // Overlong forms, surrogates and values above 0x10FFFF.
        if ((lead == 8'hE0 && seq_win[pos + 1] < 8'hA0) ||
            (lead == 8'hED && seq_win[pos + 1] >= 8'hA0))
            return SEQ_BAD;
        if ((lead == 8'hF0 && seq_win[pos + 1] < 8'h90) ||
            (lead == 8'hF4 && seq_win[pos + 1] > 8'h8F))
            return SEQ_BAD;
        seq_len = need;
        return SEQ_GOOD;
    endfunction

    function automatic bit cp_is_safe(input logic [20:0] cp);
        if (cp == 21'h0D || cp == 21'h0A || cp == 21'h09)
            return 1'b1;
        if (cp < 21'h20 || (cp >= 21'h7F && cp <= 21'h9F))
            return 1'b0;
        if (cp == 21'h2028 || cp == 21'h2029)
            return 1'b0;
        if ((cp >= 21'h202A && cp <= 21'h202E) || (cp >= 21'h2066 && cp <= 21'h2069))
            return 1'b0;
        return 1'b1;
    endfunction

    // The newest result of a step is held back so that the end mark can be set on it.
    task automatic emit_out(input logic [7:0] b, input bit has);
        if (step_has_tail)
            expected_out.push_back(step_tail);
        step_tail.out_byte    = b;
        step_tail.has_byte    = has;
        step_tail.msg_end     = 1'b0;
        step_tail.total_count = sent_n[15:0];
        step_has_tail         = 1'b1;
    endtask

    task automatic sanitize_byte(input logic [7:0] in_byte, input bit in_last);
        int          lim;
        int          len;
        int          pos;
        int          k;
        int          i;
        logic [20:0] cp;
        seq_status_t st;
        step_has_tail = 1'b0;
        lim = (limit_q > MAX_LEN) ? int'(MAX_LEN) : int'(limit_q);
        if (!overflowed && sent_n < lim)
        begin
            len = held_n;
            for (i = 0; i < len; i++)
                seq_win[i] = held_bytes[i];
            seq_win[len] = in_byte;
            len++;
            pos = 0;
            while (pos < len && sent_n < lim)
            begin
                st = decode_seq_at(pos, len - pos, in_last, k, cp);
                if (st == SEQ_SHORT)
                    break;
                if (st == SEQ_BAD || !cp_is_safe(cp))
                begin
                    sent_n++;
                    emit_out(QMARK, 1'b1);
                    pos += (st == SEQ_BAD) ? 1 : k;
                    continue;
                end
                if (sent_n + k > lim)
                begin
                    overflowed = 1'b1;
                    break;
                end
                for (i = 0; i < k; i++)
                begin
                    sent_n++;
                    emit_out(seq_win[pos + i], 1'b1);
                end
                pos += k;
            end
            held_n = 0;
            if (!overflowed && sent_n < lim && pos < len)
            begin
                for (i = 0; pos + i < len && i < 3; i++)
                    held_bytes[i] = seq_win[pos + i];
                held_n = i;
            end
        end
        else
            held_n = 0;
        if (in_last)
        begin
            if (!step_has_tail)
                emit_out(8'h00, 1'b0);
            step_tail.msg_end = 1'b1;
            held_n     = 0;
            sent_n     = 0;
            overflowed = 1'b0;
        end
        if (step_has_tail)
            expected_out.push_back(step_tail);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        gap = 0;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct && gap < 20)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        forever
        begin
            @(posedge clk);
            if (s_tready)
                break;
        end
        sanitize_byte(b, last);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_byte_limit(input logic [15:0] value);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        limit_q = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_codepoint(input logic [20:0] cp);
        if (cp < 21'h80)
            msg_bytes.push_back(cp[7:0]);
        else if (cp < 21'h800)
        begin
            msg_bytes.push_back({3'b110, cp[10:6]});
            msg_bytes.push_back({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            msg_bytes.push_back({4'b1110, cp[15:12]});
            msg_bytes.push_back({2'b10, cp[11:6]});
            msg_bytes.push_back({2'b10, cp[5:0]});
        end
        else
        begin
            msg_bytes.push_back({5'b11110, cp[20:18]});
            msg_bytes.push_back({2'b10, cp[17:12]});
            msg_bytes.push_back({2'b10, cp[11:6]});
            msg_bytes.push_back({2'b10, cp[5:0]});
        end
    endtask

    // Valid codepoints, with the unsafe ones well represented.
    function automatic logic [20:0] pick_codepoint();
        logic [20:0] cp;
        case ($urandom_range(9))
            0: cp = 21'($urandom_range(31));
            1: cp = 21'($urandom_range(8'h9F, 8'h7F));
            2:
            begin
                case ($urandom_range(2))
                    0: cp = 21'($urandom_range(16'h2029, 16'h2028));
                    1: cp = 21'($urandom_range(16'h202E, 16'h202A));
                    default: cp = 21'($urandom_range(16'h2069, 16'h2066));
                endcase
            end
            3, 4: cp = 21'($urandom_range(8'h7E, 8'h20));
            5:
            begin
                case ($urandom_range(2))
                    0: cp = 21'h09;
                    1: cp = 21'h0A;
                    default: cp = 21'h0D;
                endcase
            end
            6: cp = 21'($urandom_range(16'h07FF, 16'h00A0));
            7: cp = 21'($urandom_range(16'hFFFF, 16'h0800));
            8: cp = 21'($urandom_range(24'h10FFFF, 24'h010000));
            default: cp = 21'($urandom_range(24'h10FFFF, 0));
        endcase
        if (cp >= 21'hD800 && cp <= 21'hDFFF)
            cp = cp - 21'h800;
        return cp;
    endfunction

    task automatic add_bad_piece();
        case ($urandom_range(7))
            0: msg_bytes.push_back(8'($urandom_range(255)));
            1: msg_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
            2: msg_bytes.push_back($urandom_range(1) ? 8'($urandom_range(8'hC1, 8'hC0))
                                                     : 8'($urandom_range(8'hFF, 8'hF5)));
            3:
            begin
                msg_bytes.push_back(8'hE0);
                msg_bytes.push_back(8'($urandom_range(8'h9F, 8'h80)));
                msg_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
            end
            4:
            begin
                msg_bytes.push_back(8'hED);
                msg_bytes.push_back(8'($urandom_range(8'hBF, 8'hA0)));
                msg_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
            end
            5:
            begin
                msg_bytes.push_back(8'hF0);
                msg_bytes.push_back(8'($urandom_range(8'h8F, 8'h80)));
                msg_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
                msg_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
            end
            6:
            begin
                msg_bytes.push_back(8'hF4);
                msg_bytes.push_back(8'($urandom_range(8'hBF, 8'h90)));
                msg_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
                msg_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
            end
            default:
            begin
                // A lead byte followed by something that is not a continuation.
                msg_bytes.push_back(8'($urandom_range(8'hF4, 8'hC2)));
                msg_bytes.push_back($urandom_range(1) ? 8'($urandom_range(8'h7F, 0))
                                                      : 8'($urandom_range(8'hFF, 8'hC0)));
            end
        endcase
    endtask

    task automatic build_message();
        int units;
        int r;
        int start;
        int cut;
        msg_bytes.delete();
        units = $urandom_range(8, 1);
        for (int u = 0; u < units; u++)
        begin
            r = $urandom_range(99);
            if (r < 60)
                add_codepoint(pick_codepoint());
            else if (r < 75)
            begin
                start = msg_bytes.size();
                add_codepoint(pick_codepoint());
                if (msg_bytes.size() - start > 1)
                begin
                    cut = $urandom_range(msg_bytes.size() - start - 1, 1);
                    repeat (cut) void'(msg_bytes.pop_back());
                end
            end
            else
                add_bad_piece();
        end
    endtask

    // Controls, bidi marks, overlong forms, surrogates, out-of-range values and
    // a sequence cut short by the end of the message, under the reset limit.
    task automatic test_decode_cases();
        tx_idle_pct = 27;
        rx_idle_pct = 75;
        msg_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h85, 8'hE2, 8'h80, 8'hAE,
                      8'hE0, 8'h80, 8'h41, 8'hED, 8'hA0, 8'h80,
                      8'hF4, 8'h90, 8'h80, 8'h80, 8'hF0, 8'h9F, 8'h98, 8'h80,
                      8'hFF, 8'hE2, 8'h82};
        send_message();
    endtask

    // A four-byte sequence that does not fit stops the message; the rest is ignored.
    task automatic test_sequence_overflow();
        write_byte_limit(16'd4);
        msg_bytes = '{8'h41, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h42};
        send_message();
    endtask

    task automatic test_random_traffic(input logic [15:0] limit, input int tx_pct,
                                       input int rx_pct);
        int sent;
        sent = 0;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        write_byte_limit(limit);
        while (sent < PHASE_ITEMS)
        begin
            build_message();
            sent += msg_bytes.size();
            send_message();
        end
    endtask

    // The receiver holds off while a long message keeps arriving, so the input stalls; random traffic follows.
    task automatic test_input_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_byte_limit(BYTE_LIMIT_RESET);
        hold_request = 1'b1;
        msg_bytes.delete();
        repeat (24) add_codepoint(21'($urandom_range(8'h7E, 8'h20)));
        send_message();
        test_random_traffic(BYTE_LIMIT_RESET, 0, 0);
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        uts_result_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_out.size() == 0)
            begin
                $error("result beat with nothing expected: out_byte %h has_byte %b",
                       m_tdata[7:0], m_tuser);
                mismatches++;
            end
            else
            begin
                want = expected_out.pop_front();
                if (m_tdata[7:0] !== want.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", want.out_byte, m_tdata[7:0]);
                    mismatches++;
                end
                if (m_tuser !== want.has_byte)
                begin
                    $error("has_byte: expected %b, got %b", want.has_byte, m_tuser);
                    mismatches++;
                end
                if (m_tlast !== want.msg_end)
                begin
                    $error("msg_end: expected %b, got %b", want.msg_end, m_tlast);
                    mismatches++;
                end
                if (m_tdata[23:8] !== want.total_count)
                begin
                    $error("total_count: expected %0d, got %0d", want.total_count,
                           m_tdata[23:8]);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_decode_cases();
        test_sequence_overflow();
        test_random_traffic(16'hFFFF, 27, 75);
        test_random_traffic(16'd0, 27, 75);
        test_random_traffic(16'($urandom_range(24, 2)), 75, 27);
        test_random_traffic(16'd1, 75, 27);
        test_random_traffic(16'($urandom_range(40, 2)), 0, 0);
        test_input_backpressure();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/uts_pkg.sv
sv/uts_front.sv
sv/uts_queue.sv
sv/uts_back.sv
sv/utf8_terminal_text_sanitizer.sv
dv/tb_utf8_terminal_text_sanitizer.sv
